// ===== hdl/kttb_pkg.sv =====
// Shared types and codes for the keyed title table.
`default_nettype none

package kttb_pkg;

  localparam int unsigned WINDOW_W   = 8;
  localparam int unsigned POSITION_W = 3;
  localparam int unsigned HANDLE_W   = 32;

  typedef enum logic [1:0] {
    REQ_SET    = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_FIND   = 2'd2
  } req_e_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_e_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]   handle;
    logic [POSITION_W-1:0] position;
    logic [WINDOW_W-1:0]   window;
  } entry_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] found_handle;
    status_e_t           status;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/keyed_title_table.sv =====
// Keyed title table top level: stream ports, sequencer, entry memory and output register.
//
//   channel | dir | tdata (low bit up)                         | tuser
//   s_      | in  | window_key 8, position_key 3, title_handle 32 | req_type 2
//   m_      | out | found_handle 32                              | status 2
//
// Each item passes through the states IDLE (accept), SCAN (one memory read per
// entry), DRAIN (compare the last read) and UPDATE (write back).
// The single read port of the entry memory means the entries are read one at a time.
// Reset clears all entries at once through per-entry valid bits.
// A finished result waits in the output register; the next item is accepted
// and scanned meanwhile, and only its write-back waits for the register.
`default_nettype none

module keyed_title_table #(
  parameter int unsigned ENTRIES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // window_key[7:0], position_key[10:8], title_handle[42:11]
  input  wire logic [1:0]  s_tuser,   // req_type[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // found_handle[31:0]
  output logic [1:0]       m_tuser    // status[1:0]
);
  import kttb_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  entry_t        rd_entry;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_entry;
  logic          out_free;
  logic          res_valid;
  result_t       res;

  assign out_free = !m_tvalid || m_tready;

  kttb_ctrl #(
    .ENTRIES(ENTRIES),
    .IW     (IW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_req     (s_tuser),
    .in_window  (s_tdata[7:0]),
    .in_position(s_tdata[10:8]),
    .in_handle  (s_tdata[42:11]),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_entry   (rd_entry),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_entry   (wr_entry),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  kttb_store #(
    .ENTRIES(ENTRIES),
    .IW     (IW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_entry(rd_entry),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_entry(wr_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= res.found_handle;
      m_tuser <= res.status;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/kttb_store.sv =====
// Entry memory with one registered read port, one write port and per-entry valid bits.
`default_nettype none

module kttb_store #(
  parameter int unsigned ENTRIES = 32,
  parameter int unsigned IW      = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rd_en,
  input  wire logic [IW-1:0]    rd_addr,
  output kttb_pkg::entry_t      rd_entry,
  input  wire logic             wr_en,
  input  wire logic [IW-1:0]    wr_addr,
  input  wire kttb_pkg::entry_t wr_entry
);
  import kttb_pkg::*;

  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  entry_t             rd_data;
  logic               rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // An entry never written since reset reads as all zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= valid[rd_addr];
      end
    end
  end

  assign rd_entry = rd_vld ? rd_data : '0;

endmodule

`default_nettype wire

// ===== hdl/kttb_ctrl.sv =====
// Request sequencer: scans the memory for key match and free entry, then updates it on a set or delete.
`default_nettype none

module kttb_ctrl #(
  parameter int unsigned ENTRIES = 32,
  parameter int unsigned IW      = 5
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [1:0]                           in_req,
  input  wire logic [kttb_pkg::WINDOW_W-1:0]        in_window,
  input  wire logic [kttb_pkg::POSITION_W-1:0]      in_position,
  input  wire logic [kttb_pkg::HANDLE_W-1:0]        in_handle,
  output logic                                      rd_en,
  output logic [IW-1:0]                             rd_addr,
  input  wire kttb_pkg::entry_t                     rd_entry,
  output logic                                      wr_en,
  output logic [IW-1:0]                             wr_addr,
  output kttb_pkg::entry_t                          wr_entry,
  input  wire logic                                 out_free,
  output logic                                      res_valid,
  output kttb_pkg::result_t                         res
);
  import kttb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  state_t                state;
  logic [IW-1:0]         idx;
  logic                  chk_vld;
  logic [IW-1:0]         chk_idx;
  req_e_t                req;
  logic [WINDOW_W-1:0]   key_window;
  logic [POSITION_W-1:0] key_position;
  logic [HANDLE_W-1:0]   new_handle;
  logic                  hit_found;
  logic [IW-1:0]         hit_idx;
  logic [HANDLE_W-1:0]   hit_handle;
  logic                  free_found;
  logic [IW-1:0]         free_idx;
  logic                  key_match;

  assign in_ready  = (state == ST_IDLE);
  assign rd_en     = (state == ST_SCAN);
  assign rd_addr   = idx;
  assign key_match = (rd_entry.window == key_window) && (rd_entry.position == key_position);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      chk_vld    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      chk_vld <= (state == ST_SCAN);
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state      <= ST_SCAN;
            idx        <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (idx == LAST_IDX) begin
            state <= ST_DRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // Read data arrives in the cycle after its address; keep only the first hits.
      if (chk_vld) begin
        if (!hit_found && key_match) begin
          hit_found <= 1'b1;
        end
        if (!free_found && (rd_entry.handle == '0)) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= idx;
    if (in_valid && in_ready) begin
      req          <= req_e_t'(in_req);
      key_window   <= in_window;
      key_position <= in_position;
      new_handle   <= in_handle;
    end
    if (chk_vld && !hit_found && key_match) begin
      hit_idx    <= chk_idx;
      hit_handle <= rd_entry.handle;
    end
    if (chk_vld && !free_found && (rd_entry.handle == '0)) begin
      free_idx <= chk_idx;
    end
  end

  always_comb begin
    wr_en                 = 1'b0;
    wr_addr               = hit_idx;
    wr_entry.window       = key_window;
    wr_entry.position     = key_position;
    wr_entry.handle       = new_handle;
    res.found_handle      = '0;
    res.status            = STAT_DONE;
    res_valid             = (state == ST_UPDATE) && out_free;
    case (req)
      REQ_SET: begin
        if (hit_found) begin
          wr_en = res_valid;
        end else if (free_found) begin
          wr_en   = res_valid;
          wr_addr = free_idx;
        end else begin
          res.status = STAT_FULL;
        end
      end
      REQ_DELETE: begin
        wr_entry.handle = '0;
        if (hit_found) begin
          wr_en = res_valid;
        end else begin
          res.status = STAT_NOT_FOUND;
        end
      end
      REQ_FIND: begin
        if (hit_found) begin
          res.found_handle = hit_handle;
        end else begin
          res.status = STAT_NOT_FOUND;
        end
      end
      default: begin
        res.status = STAT_DONE;
      end
    endcase
  end

  a_write_only_on_finish: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> res_valid && (state == ST_UPDATE))
    else $error("memory write outside of the update step");

  a_full_means_no_slot: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == STAT_FULL) |-> (req == REQ_SET) && !hit_found && !free_found)
    else $error("table full reported while a slot was available");

  a_scan_ends_in_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && (idx == LAST_IDX) |=> (state == ST_DRAIN) && chk_vld)
    else $error("scan did not end after the last entry");

  a_no_read_while_writing: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en))
    else $error("read and write issued in the same cycle");

  a_found_only_on_find: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.found_handle != '0) |-> (req == REQ_FIND) && hit_found)
    else $error("handle returned for a request that is not a find hit");

endmodule

`default_nettype wire

// ===== test/tb_keyed_title_table.sv =====
// Self-checking testbench for the keyed title table: directed rows, then random request mixes.
`default_nettype none

module tb_keyed_title_table;
  import kttb_pkg::*;

  localparam int ENTRIES = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  req;
    logic [7:0]  window;
    logic [2:0]  position;
    logic [31:0] handle;
    bit          typed;
    result_t     res;
  } directed_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  // Shadow copy of the entry store.
  logic [7:0]  shadow_window   [ENTRIES];
  logic [2:0]  shadow_position [ENTRIES];
  logic [31:0] shadow_handle   [ENTRIES];

  result_t pending_results[$];
  result_t oldest_result;
  int      mismatch_count = 0;
  int      stall_cycles = 0;
  bit      calm = 1'b0;

  logic [7:0] key_pool_window   [64];
  logic [2:0] key_pool_position [64];

  directed_row_t directed_rows [22] = '{
    '{REQ_FIND,   8'h00, 3'd0, 32'h00000000, 1'b1, '{32'h00000000, STAT_DONE}},
    '{REQ_FIND,   8'h05, 3'd1, 32'h00000000, 1'b1, '{32'h00000000, STAT_NOT_FOUND}},
    '{REQ_DELETE, 8'h09, 3'd2, 32'h00000000, 1'b1, '{32'h00000000, STAT_NOT_FOUND}},
    '{REQ_DELETE, 8'h00, 3'd0, 32'h00000000, 1'b1, '{32'h00000000, STAT_DONE}},
    '{REQ_SET,    8'h00, 3'd0, 32'hFFFFFFFF, 1'b1, '{32'h00000000, STAT_DONE}},
    '{REQ_FIND,   8'h00, 3'd0, 32'h00000000, 1'b1, '{32'hFFFFFFFF, STAT_DONE}},
    '{REQ_SET,    8'hFF, 3'd7, 32'h00000001, 1'b1, '{32'h00000000, STAT_DONE}},
    '{REQ_FIND,   8'hFF, 3'd7, 32'h00000000, 1'b1, '{32'h00000001, STAT_DONE}},
    '{REQ_SET,    8'hFF, 3'd7, 32'h00000000, 1'b1, '{32'h00000000, STAT_DONE}},
    '{REQ_FIND,   8'hFF, 3'd7, 32'hFFFFFFFF, 1'b1, '{32'h00000000, STAT_DONE}},
    '{REQ_SET,    8'hAA, 3'd5, 32'hA5A5A5A5, 1'b1, '{32'h00000000, STAT_DONE}},
    '{REQ_FIND,   8'hFF, 3'd7, 32'h00000000, 1'b1, '{32'h00000000, STAT_NOT_FOUND}},
    '{REQ_FIND,   8'hAA, 3'd5, 32'h00000000, 1'b1, '{32'hA5A5A5A5, STAT_DONE}},
    '{REQ_UNUSED, 8'hAA, 3'd5, 32'h12345678, 1'b1, '{32'h00000000, STAT_DONE}},
    '{REQ_FIND,   8'hAA, 3'd5, 32'h00000000, 1'b1, '{32'hA5A5A5A5, STAT_DONE}},
    '{REQ_DELETE, 8'hAA, 3'd5, 32'h00000000, 1'b1, '{32'h00000000, STAT_DONE}},
    '{REQ_FIND,   8'hAA, 3'd5, 32'h00000000, 1'b1, '{32'h00000000, STAT_DONE}},
    '{REQ_SET,    8'h55, 3'd2, 32'h5A5A5A5A, 1'b0, '{32'h00000000, STAT_DONE}},
    '{REQ_SET,    8'h55, 3'd2, 32'h87654321, 1'b0, '{32'h00000000, STAT_DONE}},
    '{REQ_FIND,   8'h55, 3'd2, 32'h00000000, 1'b0, '{32'h00000000, STAT_DONE}},
    '{REQ_SET,    8'h00, 3'd0, 32'h00000000, 1'b0, '{32'h00000000, STAT_DONE}},
    '{REQ_FIND,   8'h80, 3'd4, 32'h00000000, 1'b0, '{32'h00000000, STAT_DONE}}
  };

  keyed_title_table #(.ENTRIES(ENTRIES)) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_window[i] = '0;
      shadow_position[i] = '0;
      shadow_handle[i] = '0;
    end
  end

  // Applies one request to the shadow store and returns the answer the block should give.
  function automatic result_t predict_title_request(input logic [1:0] req,
                                                    input logic [7:0] window,
                                                    input logic [2:0] position,
                                                    input logic [31:0] handle);
    result_t res;
    int      slot;
    res.found_handle = '0;
    res.status = STAT_DONE;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && shadow_window[i] == window && shadow_position[i] == position) slot = i;
    end
    case (req)
      REQ_SET: begin
        // Only when no keys match does the first empty entry take the write.
        if (slot < 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && shadow_handle[i] == '0) slot = i;
          end
        end
        if (slot < 0) begin
          res.status = STAT_FULL;
        end else begin
          shadow_window[slot] = window;
          shadow_position[slot] = position;
          shadow_handle[slot] = handle;
        end
      end
      REQ_DELETE: begin
        if (slot < 0) res.status = STAT_NOT_FOUND;
        else shadow_handle[slot] = '0;
      end
      REQ_FIND: begin
        if (slot < 0) res.status = STAT_NOT_FOUND;
        else res.found_handle = shadow_handle[slot];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Presents one item, waits for it to be taken, and queues the answer it should produce.
  task automatic send_item(input logic [1:0] req, input logic [7:0] window,
                           input logic [2:0] position, input logic [31:0] handle,
                           input bit typed, input result_t typed_res);
    result_t predicted;
    if (!calm && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 20);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, handle, position, window};
    s_tuser <= req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_title_request(req, window, position, handle);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic settle_outputs();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random requests; at least half of the keys come from a small pool so that matches and a full table occur.
  task automatic run_phase(input int pool_size, input int set_pct, input int delete_pct,
                           input int unused_pct, input int wild_pct, input int count);
    int          roll;
    int          idx;
    logic [1:0]  req;
    logic [7:0]  window;
    logic [2:0]  position;
    logic [31:0] handle;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < unused_pct) req = REQ_UNUSED;
      else if (roll < unused_pct + set_pct) req = REQ_SET;
      else if (roll < unused_pct + set_pct + delete_pct) req = REQ_DELETE;
      else req = REQ_FIND;
      if ($urandom_range(99) < wild_pct) begin
        window = 8'($urandom_range(255));
        position = 3'($urandom_range(7));
      end else begin
        idx = $urandom_range(pool_size - 1);
        window = key_pool_window[idx];
        position = key_pool_position[idx];
      end
      roll = $urandom_range(19);
      if (roll < 2) handle = '0;
      else if (roll == 2) handle = '1;
      else handle = $urandom;
      send_item(req, window, position, handle, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected item: handle %h status %0d", m_tdata, m_tuser);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (m_tdata !== oldest_result.found_handle || m_tuser !== oldest_result.status) begin
          if (mismatch_count < 10)
            $display("mismatch: expected handle %h status %0d, got handle %h status %0d",
                     oldest_result.found_handle, oldest_result.status, m_tdata, m_tuser);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[keyed_title_table] ERROR");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 64; i++) begin
      key_pool_window[i] = 8'($urandom_range(255));
      key_pool_position[i] = 3'($urandom_range(7));
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i])
      send_item(directed_rows[i].req, directed_rows[i].window, directed_rows[i].position,
                directed_rows[i].handle, directed_rows[i].typed, directed_rows[i].res);
    settle_outputs();
    run_phase(6, 40, 30, 0, 10, 250);
    settle_outputs();
    run_phase(64, 75, 5, 0, 10, 250);
    settle_outputs();
    calm <= 1'b1;
    run_phase(64, 50, 25, 0, 10, 250);
    calm <= 1'b0;
    run_phase(40, 45, 25, 4, 15, 250);
    settle_outputs();
    run_phase(64, 50, 20, 0, 50, 250);
    settle_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[keyed_title_table] OK");
    end else begin
      $display("[keyed_title_table] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
